>>> design/pss_pkg.sv
package pss_pkg;

    localparam int TASK_SLOTS = 16;
    localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    localparam int ID_W    = 8;
    localparam int BURST_W = 16;
    localparam int PRI_W   = 8;
    localparam int TIME_W  = 32;
    localparam int KEY_W   = 16;
    localparam int STAT_W  = 2;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 144;

    // opcodes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] RES_ADDED = 2'd0;
    localparam logic [STAT_W-1:0] RES_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] RES_RAN   = 2'd2;
    localparam logic [STAT_W-1:0] RES_IDLE  = 2'd3;

    // key_mode values
    localparam logic MODE_SRTF = 1'b0;
    localparam logic MODE_PRIO = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_PICK,
        S_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic add_do;
        logic scan_step;
        logic run_do;
        logic wait_do;
        logic idle_do;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic found;
    } sts_t;

endpackage

>>> design/preemptive_srtf_priority_scheduler_unit.sv
// Channel   | Dir | Handshake              | Payload
// ----------+-----+------------------------+--------------------------------------
// s_        | in  | s_tvalid / s_tready    | tuser: opcode; tdata: id, burst, prio
// m_        | out | m_tvalid / m_tready    | tuser: status; tdata: see port
// cfg_      | in  | cfg_valid / cfg_ready  | cfg_data: key_mode
//
// Add: ADD, then DONE loads the output register. Run tick: a scan of every slot,
// then PICK, WAIT and DONE; an idle tick skips WAIT. The single-comparator scan
// visits one slot per cycle; a new item is accepted only back in IDLE.
// Synchronous reset empties the slot table, clears the time and selects SRTF.
// A waiting result does not block the next accept; an item stalls only when
// its own result finds the output register still full.
module preemptive_srtf_priority_scheduler_unit
    import pss_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,     // key_mode
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tuser,      // [0] opcode
    // [7:0] task_id, [23:8] burst_length, [31:24] priority_level
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [STAT_W-1:0]    m_tuser,      // [1:0] status
    // [7:0] ran_id, [8] finished, [40:9] time_now, [72:41] turnaround,
    // [104:73] waiting, [136:105] response, [143:137] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    cmd_t cmd;
    sts_t sts;

    logic [ID_W-1:0]   ran_id;
    logic              finished;
    logic [TIME_W-1:0] time_now;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [TIME_W-1:0] response;

    // mode must only be written while idle (the block does not enforce it), so it is always taken
    assign cfg_ready = 1'b1;

    pss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_op    (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    pss_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .s_tdata        (s_tdata),
        .cmd            (cmd),
        .sts            (sts),
        .out_status     (m_tuser),
        .out_ran_id     (ran_id),
        .out_finished   (finished),
        .out_time_now   (time_now),
        .out_turnaround (turnaround),
        .out_waiting    (waiting),
        .out_response   (response)
    );

    assign m_tdata = {7'd0, response, waiting, turnaround, time_now, finished, ran_id};

endmodule

>>> design/pss_ctrl.sv
module pss_ctrl
    import pss_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic in_op,
    input  logic m_tready,
    output logic m_tvalid,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = (in_op == OP_TICK) ? S_SCAN : S_ADD;
                end
            end
            S_ADD:  state_next = S_DONE;
            S_SCAN: begin
                if (sts.scan_last) begin
                    state_next = S_PICK;
                end
            end
            S_PICK: state_next = sts.found ? S_WAIT : S_DONE;
            S_WAIT: state_next = S_DONE;
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            S_ADD:  cmd.add_do    = 1'b1;
            S_SCAN: cmd.scan_step = 1'b1;
            S_PICK: begin
                cmd.run_do  = sts.found;
                cmd.idle_do = !sts.found;
            end
            S_WAIT: cmd.wait_do = 1'b1;
            S_DONE: cmd.out_load = !m_tvalid_reg || m_tready;
            default: cmd = '0;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten while stalled");

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_ADD || state_reg == S_SCAN))
        else $error("accepted item not dispatched");

    a_pick_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PICK) |=> (state_reg == S_WAIT || state_reg == S_DONE))
        else $error("bad exit from pick");

endmodule

>>> design/pss_dp.sv
module pss_dp
    import pss_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_data,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic [STAT_W-1:0]    out_status,
    output logic [ID_W-1:0]      out_ran_id,
    output logic                 out_finished,
    output logic [TIME_W-1:0]    out_time_now,
    output logic [TIME_W-1:0]    out_turnaround,
    output logic [TIME_W-1:0]    out_waiting,
    output logic [TIME_W-1:0]    out_response
);

    logic                  key_mode_reg;
    logic [TIME_W-1:0]     clock_reg;

    logic [ID_W-1:0]       id_in_reg;
    logic [BURST_W-1:0]    burst_in_reg;
    logic [PRI_W-1:0]      pri_in_reg;

    logic [TASK_SLOTS-1:0] busy_reg;
    logic [ID_W-1:0]       id_mem      [TASK_SLOTS];
    logic [BURST_W-1:0]    rem_mem     [TASK_SLOTS];
    logic [BURST_W-1:0]    burst_mem   [TASK_SLOTS];
    logic [PRI_W-1:0]      pri_mem     [TASK_SLOTS];
    logic [TIME_W-1:0]     arr_mem     [TASK_SLOTS];
    logic [TIME_W-1:0]     frt_mem     [TASK_SLOTS];
    logic                  started_mem [TASK_SLOTS];

    logic [SLOT_W-1:0]     scan_idx_reg;
    logic [SLOT_W-1:0]     best_idx_reg;
    logic [KEY_W-1:0]      best_key_reg;
    logic [TIME_W-1:0]     best_age_reg;
    logic                  found_reg;

    logic [STAT_W-1:0]     res_status_reg;
    logic [ID_W-1:0]       res_ran_reg;
    logic                  res_fin_reg;
    logic [TIME_W-1:0]     res_tat_reg;
    logic [TIME_W-1:0]     res_wait_reg;
    logic [TIME_W-1:0]     res_resp_reg;

    logic [STAT_W-1:0]     out_status_reg;
    logic [ID_W-1:0]       out_ran_reg;
    logic                  out_fin_reg;
    logic [TIME_W-1:0]     out_time_reg;
    logic [TIME_W-1:0]     out_tat_reg;
    logic [TIME_W-1:0]     out_wait_reg;
    logic [TIME_W-1:0]     out_resp_reg;

    // free slot search
    logic                  full;
    logic [SLOT_W-1:0]     free_idx;

    always_comb begin
        full     = 1'b1;
        free_idx = '0;
        for (int s = TASK_SLOTS - 1; s >= 0; s--) begin
            if (!busy_reg[s]) begin
                full     = 1'b0;
                free_idx = SLOT_W'(s);
            end
        end
    end

    // one read port, walked by the scan, then parked on the winner
    logic [SLOT_W-1:0]  rd_idx;
    logic [KEY_W-1:0]   rd_key;
    logic [TIME_W-1:0]  rd_age;
    logic               better;
    logic [BURST_W-1:0] rem_new;
    logic [TIME_W-1:0]  clock_inc;
    logic [TIME_W-1:0]  first_run;
    logic               fin_now;

    assign rd_idx = cmd.scan_step ? scan_idx_reg : best_idx_reg;
    assign rd_key = (key_mode_reg == MODE_PRIO) ? KEY_W'(pri_mem[rd_idx]) : rem_mem[rd_idx];
    assign rd_age = clock_reg - arr_mem[rd_idx];
    assign better = busy_reg[rd_idx] &&
                    (!found_reg || (rd_key < best_key_reg) ||
                     ((rd_key == best_key_reg) && (rd_age > best_age_reg)));

    // a zero burst still runs one unit and then finishes
    assign rem_new   = (rem_mem[rd_idx] != '0) ? rem_mem[rd_idx] - BURST_W'(1) : '0;
    assign fin_now   = (rem_new == '0);
    assign clock_inc = clock_reg + TIME_W'(1);
    assign first_run = started_mem[rd_idx] ? frt_mem[rd_idx] : clock_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_mode_reg <= MODE_SRTF;
            clock_reg    <= '0;
            busy_reg     <= '0;
            found_reg    <= 1'b0;
            scan_idx_reg <= '0;
        end else begin
            if (cfg_valid) begin
                key_mode_reg <= cfg_data;
            end
            if (cmd.load_in) begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            if (cmd.scan_step) begin
                scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
                if (better) begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.add_do && !full) begin
                busy_reg[free_idx] <= 1'b1;
            end
            if (cmd.run_do) begin
                clock_reg <= clock_inc;
                if (fin_now) begin
                    busy_reg[rd_idx] <= 1'b0;
                end
            end
            if (cmd.idle_do) begin
                clock_reg <= clock_inc;
            end
        end
    end

    // slot stores, payload only
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            id_in_reg    <= s_tdata[ID_W-1:0];
            burst_in_reg <= s_tdata[ID_W +: BURST_W];
            pri_in_reg   <= s_tdata[ID_W+BURST_W +: PRI_W];
        end
        if (cmd.add_do && !full) begin
            id_mem[free_idx]      <= id_in_reg;
            burst_mem[free_idx]   <= burst_in_reg;
            rem_mem[free_idx]     <= burst_in_reg;
            pri_mem[free_idx]     <= pri_in_reg;
            arr_mem[free_idx]     <= clock_reg;
            started_mem[free_idx] <= 1'b0;
        end
        if (cmd.scan_step && better) begin
            best_idx_reg <= scan_idx_reg;
            best_key_reg <= rd_key;
            best_age_reg <= rd_age;
        end
        if (cmd.run_do) begin
            rem_mem[rd_idx]     <= rem_new;
            started_mem[rd_idx] <= 1'b1;
            frt_mem[rd_idx]     <= first_run;
        end
    end

    // working result
    always_ff @(posedge aclk) begin
        if (cmd.add_do) begin
            res_status_reg <= full ? RES_FULL : RES_ADDED;
            res_ran_reg    <= '0;
            res_fin_reg    <= 1'b0;
            res_tat_reg    <= '0;
            res_wait_reg   <= '0;
            res_resp_reg   <= '0;
        end
        if (cmd.idle_do) begin
            res_status_reg <= RES_IDLE;
            res_ran_reg    <= '0;
            res_fin_reg    <= 1'b0;
            res_tat_reg    <= '0;
            res_wait_reg   <= '0;
            res_resp_reg   <= '0;
        end
        if (cmd.run_do) begin
            res_status_reg <= RES_RAN;
            res_ran_reg    <= id_mem[rd_idx];
            res_fin_reg    <= fin_now;
            res_tat_reg    <= fin_now ? clock_inc - arr_mem[rd_idx] : '0;
            res_resp_reg   <= fin_now ? first_run - arr_mem[rd_idx] : '0;
        end
        if (cmd.wait_do) begin
            res_wait_reg <= res_fin_reg ?
                            res_tat_reg - {{(TIME_W-BURST_W){1'b0}}, burst_mem[rd_idx]} : '0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_ran_reg    <= res_ran_reg;
            out_fin_reg    <= res_fin_reg;
            out_time_reg   <= clock_reg;
            out_tat_reg    <= res_tat_reg;
            out_wait_reg   <= res_wait_reg;
            out_resp_reg   <= res_resp_reg;
        end
    end

    assign sts.scan_last = (scan_idx_reg == SLOT_W'(TASK_SLOTS - 1));
    assign sts.found     = found_reg;

    assign out_status     = out_status_reg;
    assign out_ran_id     = out_ran_reg;
    assign out_finished   = out_fin_reg;
    assign out_time_now   = out_time_reg;
    assign out_turnaround = out_tat_reg;
    assign out_waiting    = out_wait_reg;
    assign out_response   = out_resp_reg;

    // an add into a free slot takes exactly one slot
    a_add_fills_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.add_do && !full) |=> ($countones(busy_reg) == $past($countones(busy_reg)) + 1))
        else $error("add did not fill exactly one slot");

endmodule
